// ----- src/mvhp_pkg.sv -----
`default_nettype none

package mvhp_pkg;

  // Header kinds; the two top codes are internal framer states.
  typedef enum logic [2:0] {
    KIND_SEQHDR    = 3'd0,
    KIND_SEQEXT    = 3'd1,
    KIND_DISPEXT   = 3'd2,
    KIND_PICCODEXT = 3'd3,
    KIND_GOP       = 3'd4,
    KIND_PICTURE   = 3'd5,
    KIND_EXT_ID    = 3'd6,
    KIND_NONE      = 3'd7
  } kind_t;

  localparam logic [7:0] SC_SEQHDR  = 8'hB3;
  localparam logic [7:0] SC_EXT     = 8'hB5;
  localparam logic [7:0] SC_GOP     = 8'hB8;
  localparam logic [7:0] SC_PICTURE = 8'h00;
  localparam logic [7:0] SC_PREFIX  = 8'h01;

  localparam logic [3:0] EXT_ID_SEQ     = 4'h1;
  localparam logic [3:0] EXT_ID_DISP    = 4'h2;
  localparam logic [3:0] EXT_ID_PICCOD  = 4'h8;

  localparam int GATHER_W = 56;

  // Framer to property store: one completed header.
  typedef struct packed {
    logic                  fire;      // last needed byte of a header
    kind_t                 kind;
    logic                  ext_start; // extension start code byte
    logic [GATHER_W-1:0]   bytes;     // gathered bytes, newest lowest
  } hdr_evt_t;

  typedef struct packed {
    logic        mpeg2_seen;
    logic [13:0] frame_width;
    logic [13:0] frame_height;
    logic [3:0]  aspect_code;
    logic [3:0]  rate_code;
    logic [17:0] bit_rate_units;
    logic [6:0]  profile_level;
    logic [1:0]  chroma_kind;
    logic [1:0]  scan_kind;
    logic [6:0]  rate_extension;
    logic [22:0] gop_timecode;
  } props_t;

  function automatic logic [2:0] needed_bytes(input kind_t k);
    logic [2:0] n;
    case (k)
      KIND_SEQHDR:    n = 3'd7;
      KIND_SEQEXT:    n = 3'd6;
      KIND_DISPEXT:   n = 3'd1;
      KIND_PICCODEXT: n = 3'd5;
      KIND_GOP:       n = 3'd4;
      KIND_PICTURE:   n = 3'd4;
      default:        n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- src/mpeg_video_header_parser.sv -----
`default_nettype none

// Channel   Dir  Beat                  Payload
// s_axis    in   one stream byte       tdata[7:0] data_byte
// m_axis    out  one parsed header     tuser[2:0] header_kind, tdata[95:0] properties
//
// One byte per clock while no completed header waits on a busy output. A byte is
// parsed in the input register and any result is then loaded into the output register.
// Reset (rst, synchronous) empties both registers and restores the power-up
// property set (progressive, all else zero).
// A byte that completes a header waits in the input register only while the
// output register holds an untaken result; the input stalls only then.
module mpeg_video_header_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // [0] mpeg2_seen, [14:1] frame_width, [28:15] frame_height,
  // [32:29] aspect_code, [36:33] rate_code, [54:37] bit_rate_units,
  // [61:55] profile_level, [63:62] chroma_kind, [65:64] scan_kind,
  // [72:66] rate_extension, [95:73] gop_timecode
  output      logic [95:0] m_tdata,
  output      logic [2:0]  m_tuser   // [2:0] header_kind
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               advance;
  mvhp_pkg::hdr_evt_t evt;
  mvhp_pkg::props_t   rec;

  // hold the byte only if it makes a result and the output slot is busy
  assign advance  = in_valid && !(evt.fire && m_tvalid && !m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  mvhp_framer u_framer (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .data (in_byte),
    .evt  (evt)
  );

  mvhp_props u_props (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .evt  (evt),
    .rec  (rec)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && evt.fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && evt.fire) begin
      m_tuser <= evt.kind;
      m_tdata <= {rec.gop_timecode, rec.rate_extension, rec.scan_kind,
                  rec.chroma_kind, rec.profile_level, rec.bit_rate_units,
                  rec.rate_code, rec.aspect_code, rec.frame_height,
                  rec.frame_width, rec.mpeg2_seen};
    end
  end

endmodule

`default_nettype wire

// ----- src/mvhp_framer.sv -----
`default_nettype none

// Start code hunt and header byte gathering.
module mvhp_framer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        data,
  output mvhp_pkg::hdr_evt_t     evt
);

  logic [1:0]                     zero_run, zero_run_next;
  logic                           code_pending, code_pending_next;
  mvhp_pkg::kind_t                cur_kind, cur_kind_next;
  logic [2:0]                     payload_index, payload_index_next;
  logic [mvhp_pkg::GATHER_W-1:0]  gather, gather_next;
  logic [mvhp_pkg::GATHER_W-1:0]  shifted;
  mvhp_pkg::kind_t                eff_kind;
  logic [2:0]                     idx_inc;

  assign shifted = {gather[mvhp_pkg::GATHER_W-9:0], data};
  assign idx_inc = payload_index + 3'd1;

  always_comb begin
    zero_run_next      = zero_run;
    code_pending_next  = code_pending;
    cur_kind_next      = cur_kind;
    payload_index_next = payload_index;
    gather_next        = gather;
    eff_kind           = cur_kind;
    evt.fire           = 1'b0;
    evt.kind           = cur_kind;
    evt.ext_start      = 1'b0;
    evt.bytes          = shifted;

    if (code_pending) begin
      code_pending_next  = 1'b0;
      zero_run_next      = 2'd0;
      payload_index_next = 3'd0;
      gather_next        = '0;
      case (data)
        mvhp_pkg::SC_SEQHDR:  cur_kind_next = mvhp_pkg::KIND_SEQHDR;
        mvhp_pkg::SC_EXT: begin
          cur_kind_next = mvhp_pkg::KIND_EXT_ID;
          evt.ext_start = 1'b1;
        end
        mvhp_pkg::SC_GOP:     cur_kind_next = mvhp_pkg::KIND_GOP;
        mvhp_pkg::SC_PICTURE: cur_kind_next = mvhp_pkg::KIND_PICTURE;
        default:              cur_kind_next = mvhp_pkg::KIND_NONE;
      endcase
    end else if (data == mvhp_pkg::SC_PREFIX && zero_run == 2'd2) begin
      // prefix complete: any header in progress is dropped
      cur_kind_next     = mvhp_pkg::KIND_NONE;
      code_pending_next = 1'b1;
      zero_run_next     = 2'd0;
    end else begin
      if (data == 8'h00) begin
        zero_run_next = (zero_run == 2'd2) ? 2'd2 : zero_run + 2'd1;
      end else begin
        zero_run_next = 2'd0;
      end
      if (cur_kind != mvhp_pkg::KIND_NONE) begin
        gather_next        = shifted;
        payload_index_next = idx_inc;
        if (cur_kind == mvhp_pkg::KIND_EXT_ID) begin
          case (data[7:4])
            mvhp_pkg::EXT_ID_SEQ:    eff_kind = mvhp_pkg::KIND_SEQEXT;
            mvhp_pkg::EXT_ID_DISP:   eff_kind = mvhp_pkg::KIND_DISPEXT;
            mvhp_pkg::EXT_ID_PICCOD: eff_kind = mvhp_pkg::KIND_PICCODEXT;
            default:                 eff_kind = mvhp_pkg::KIND_NONE;
          endcase
        end
        evt.kind = eff_kind;
        if (eff_kind == mvhp_pkg::KIND_NONE) begin
          cur_kind_next = mvhp_pkg::KIND_NONE;
        end else if (idx_inc == mvhp_pkg::needed_bytes(eff_kind)) begin
          evt.fire      = 1'b1;
          cur_kind_next = mvhp_pkg::KIND_NONE;
        end else begin
          cur_kind_next = eff_kind;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run      <= 2'd0;
      code_pending  <= 1'b0;
      cur_kind      <= mvhp_pkg::KIND_NONE;
      payload_index <= 3'd0;
    end else if (step) begin
      zero_run      <= zero_run_next;
      code_pending  <= code_pending_next;
      cur_kind      <= cur_kind_next;
      payload_index <= payload_index_next;
    end
  end

  // Only the bytes of the current header are ever read, so no reset.
  always_ff @(posedge clk) begin
    if (step) begin
      gather <= gather_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/mvhp_props.sv -----
`default_nettype none

// Stream property registers, updated from completed headers.
module mvhp_props (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire mvhp_pkg::hdr_evt_t evt,
  output mvhp_pkg::props_t       rec
);

  logic        mpeg2_flag, mpeg2_flag_next;
  logic [11:0] width_low, width_low_next;
  logic [11:0] height_low, height_low_next;
  logic [3:0]  size_ext, size_ext_next;
  logic [3:0]  aspect, aspect_next;
  logic [3:0]  rate, rate_next;
  logic [17:0] bitrate, bitrate_next;
  logic [6:0]  profile, profile_next;
  logic [1:0]  chroma, chroma_next;
  logic        progressive, progressive_next;
  logic        top_seen, top_seen_next;
  logic        bottom_seen, bottom_seen_next;
  logic [6:0]  rate_ext, rate_ext_next;
  logic [22:0] timecode, timecode_next;
  logic [55:0] g;

  assign g = evt.bytes;

  always_comb begin
    mpeg2_flag_next  = mpeg2_flag | evt.ext_start;
    width_low_next   = width_low;
    height_low_next  = height_low;
    size_ext_next    = size_ext;
    aspect_next      = aspect;
    rate_next        = rate;
    bitrate_next     = bitrate;
    profile_next     = profile;
    chroma_next      = chroma;
    progressive_next = progressive;
    top_seen_next    = top_seen;
    bottom_seen_next = bottom_seen;
    rate_ext_next    = rate_ext;
    timecode_next    = timecode;
    if (evt.fire) begin
      case (evt.kind)
        mvhp_pkg::KIND_SEQHDR: begin
          width_low_next  = g[55:44];
          height_low_next = g[43:32];
          aspect_next     = g[31:28];
          rate_next       = g[27:24];
          bitrate_next    = g[23:6];
        end
        mvhp_pkg::KIND_SEQEXT: begin
          profile_next     = g[42:36];
          progressive_next = g[35];
          chroma_next      = g[34:33];
          size_ext_next    = g[32:29];
          rate_ext_next    = g[6:0];
        end
        mvhp_pkg::KIND_PICCODEXT: begin
          // field order only counts on interlaced sequences
          if (!progressive) begin
            if (g[15]) begin
              top_seen_next = 1'b1;
            end else begin
              bottom_seen_next = 1'b1;
            end
          end
        end
        mvhp_pkg::KIND_GOP: begin
          timecode_next = {g[30:26], g[25:20], g[18:13], g[12:7]};
        end
        default: ;
      endcase
    end
  end

  // Result reflects the properties after this header is applied.
  always_comb begin
    rec.mpeg2_seen     = mpeg2_flag_next;
    rec.frame_width    = {size_ext_next[3:2], width_low_next};
    rec.frame_height   = {size_ext_next[1:0], height_low_next};
    rec.aspect_code    = aspect_next;
    rec.rate_code      = rate_next;
    rec.bit_rate_units = bitrate_next;
    rec.profile_level  = profile_next;
    rec.chroma_kind    = chroma_next;
    if (progressive_next) begin
      rec.scan_kind = 2'd0;
    end else if (top_seen_next == bottom_seen_next) begin
      rec.scan_kind = 2'd1;
    end else if (top_seen_next) begin
      rec.scan_kind = 2'd2;
    end else begin
      rec.scan_kind = 2'd3;
    end
    rec.rate_extension = rate_ext_next;
    rec.gop_timecode   = timecode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mpeg2_flag  <= 1'b0;
      width_low   <= '0;
      height_low  <= '0;
      size_ext    <= '0;
      aspect      <= '0;
      rate        <= '0;
      bitrate     <= '0;
      profile     <= '0;
      chroma      <= '0;
      progressive <= 1'b1;
      top_seen    <= 1'b0;
      bottom_seen <= 1'b0;
      rate_ext    <= '0;
      timecode    <= '0;
    end else if (step) begin
      mpeg2_flag  <= mpeg2_flag_next;
      width_low   <= width_low_next;
      height_low  <= height_low_next;
      size_ext    <= size_ext_next;
      aspect      <= aspect_next;
      rate        <= rate_next;
      bitrate     <= bitrate_next;
      profile     <= profile_next;
      chroma      <= chroma_next;
      progressive <= progressive_next;
      top_seen    <= top_seen_next;
      bottom_seen <= bottom_seen_next;
      rate_ext    <= rate_ext_next;
      timecode    <= timecode_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/mvhp_checker.sv -----
`default_nettype none

module mvhp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [95:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= mvhp_pkg::KIND_PICTURE)
    else $error("header kind out of range");

  // an extension header implies the MPEG-2 flag
  a_ext_mpeg2: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == mvhp_pkg::KIND_SEQEXT || m_tuser == mvhp_pkg::KIND_DISPEXT ||
                 m_tuser == mvhp_pkg::KIND_PICCODEXT)
      |-> m_tdata[0])
    else $error("extension result without mpeg2_seen");

  // with the output slot empty the input is always open
  a_in_open: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with output empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result present after reset");

endmodule

bind mpeg_video_header_parser mvhp_checker u_mvhp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
